// ----- rtl/core/rse_pkg.sv -----
// shared types and constants of the randomized set engine
package rse_pkg;

    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;
    localparam int WORD_BITS  = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int STEP_BITS  = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_REMOVE     = 2'd1,
        FUNC_CONTAINS   = 2'd2,
        FUNC_GET_RANDOM = 2'd3
    } t_rse_func;

    typedef enum logic [1:0] {
        STATUS_SUCCESS = 2'd0,
        STATUS_MISS    = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_EMPTY   = 2'd3
    } t_rse_status;

    typedef struct packed {
        t_rse_func          func;
        logic signed [31:0] value;
        logic        [31:0] random_word;
    } t_rse_in;

    typedef struct packed {
        t_rse_status        status;
        logic signed [31:0] result_value;
        logic        [8:0]  element_count;
    } t_rse_out;

endpackage

// ----- rtl/core/randomized_set_engine_unit.sv -----
// randomized set engine: dense value store with insert, remove, contains, get random
//
//  channel   ports                      handshake
//  -------   -------------------------  ---------------------------------------
//  command   start, busy, i_item        beat taken when start is high, busy low
//  result    o_valid, o_result          one-cycle strobe, receiver cannot stall
//
// insert, remove, contains: one slot read per cycle while searching (stops at the hit),
//   then the exec state, plus the remove read and write states for a remove that hits
// get random: 32-step restoring modulo by the count, then a read and an output state;
//   on an empty set it is answered at once and never goes busy
// synchronous active-low reset clears the count and the sequencer, not the store
// the result strobe lands in the first idle cycle; the receiver never stalls it
module randomized_set_engine_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  rse_pkg::t_rse_in  i_item,
    output logic              busy,
    output logic              o_valid,
    output rse_pkg::t_rse_out o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC,
        S_RM_RD,
        S_RM_WR,
        S_DIV,
        S_GR_RD,
        S_GR_OUT
    } t_state;

    t_state r_state;

    // element store, one write and one registered read port
    logic [rse_pkg::VALUE_BITS-1:0] r_mem [rse_pkg::CAPACITY];
    logic [rse_pkg::VALUE_BITS-1:0] r_rdata;

    logic                           mem_we;
    logic [rse_pkg::ADDR_BITS-1:0]  mem_waddr;
    logic [rse_pkg::VALUE_BITS-1:0] mem_wdata;
    logic [rse_pkg::ADDR_BITS-1:0]  mem_raddr;

    // sequencer state
    rse_pkg::t_rse_in               r_item;
    rse_pkg::t_rse_out              r_out;
    logic                           r_valid;
    logic [rse_pkg::COUNT_BITS-1:0] r_count;
    logic [rse_pkg::COUNT_BITS-1:0] r_idx;     // next slot to read during search
    logic [rse_pkg::ADDR_BITS-1:0]  r_pidx;    // slot whose data is in r_rdata
    logic                           r_pend;    // r_rdata holds a slot to compare
    logic                           r_found;
    logic [rse_pkg::ADDR_BITS-1:0]  r_slot;

    // modulo unit
    logic [rse_pkg::COUNT_BITS-1:0] r_rem;
    logic [rse_pkg::WORD_BITS-1:0]  r_word;
    logic [rse_pkg::STEP_BITS-1:0]  r_step;

    logic [rse_pkg::VALUE_BITS-1:0] key;
    logic [rse_pkg::COUNT_BITS-1:0] last_slot;
    logic [rse_pkg::COUNT_BITS:0]   trial;
    logic [rse_pkg::COUNT_BITS:0]   trial_diff;
    logic                           trial_ge;
    logic [rse_pkg::COUNT_BITS-1:0] next_rem;
    logic                           store_full;

    assign key        = r_item.value[rse_pkg::VALUE_BITS-1:0];
    assign last_slot  = r_count - 1'b1;
    assign store_full = (r_count >= rse_pkg::COUNT_BITS'(rse_pkg::CAPACITY));

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial      = {r_rem, r_word[rse_pkg::WORD_BITS-1]};
    assign trial_ge   = (trial >= {1'b0, r_count});
    assign trial_diff = trial - {1'b0, r_count};
    assign next_rem   = trial_ge ? trial_diff[rse_pkg::COUNT_BITS-1:0]
                                 : trial[rse_pkg::COUNT_BITS-1:0];

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    // memory write port: insert appends, remove moves the last element down
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[rse_pkg::ADDR_BITS-1:0];
        mem_wdata = key;
        if (r_state == S_EXEC && r_item.func == rse_pkg::FUNC_INSERT
            && !r_found && !store_full) begin
            mem_we = 1'b1;
        end
        if (r_state == S_RM_WR) begin
            mem_we    = 1'b1;
            mem_waddr = r_slot;
            mem_wdata = r_rdata;
        end
    end

    // memory read address
    always_comb begin
        case (r_state)
            S_RM_RD: mem_raddr = last_slot[rse_pkg::ADDR_BITS-1:0];
            S_GR_RD: mem_raddr = r_rem[rse_pkg::ADDR_BITS-1:0];
            default: mem_raddr = r_idx[rse_pkg::ADDR_BITS-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[mem_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item  <= i_item;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        if (i_item.func == rse_pkg::FUNC_GET_RANDOM) begin
                            if (r_count == '0) begin
                                // nothing to pick from
                                r_out.status        <= rse_pkg::STATUS_EMPTY;
                                r_out.result_value  <= '0;
                                r_out.element_count <= r_count;
                                r_valid             <= 1'b1;
                            end else begin
                                r_rem   <= '0;
                                r_word  <= i_item.random_word;
                                r_step  <= '0;
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end

                S_SEARCH: begin
                    // compare the slot read last cycle while the next one is read
                    if (r_pend && r_rdata == key) begin
                        r_found <= 1'b1;
                        r_slot  <= r_pidx;
                        r_state <= S_EXEC;
                    end else if (!r_pend && r_idx >= r_count) begin
                        r_state <= S_EXEC;
                    end
                    if (r_idx < r_count) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_idx[rse_pkg::ADDR_BITS-1:0];
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end

                S_EXEC: begin
                    r_out.result_value  <= '0;
                    r_out.element_count <= r_count;
                    r_state             <= S_IDLE;
                    case (r_item.func)
                        rse_pkg::FUNC_INSERT: begin
                            r_valid <= 1'b1;
                            if (r_found) begin
                                r_out.status <= rse_pkg::STATUS_MISS;
                            end else if (store_full) begin
                                r_out.status <= rse_pkg::STATUS_FULL;
                            end else begin
                                r_out.status        <= rse_pkg::STATUS_SUCCESS;
                                r_out.element_count <= r_count + 1'b1;
                                r_count             <= r_count + 1'b1;
                            end
                        end
                        rse_pkg::FUNC_REMOVE: begin
                            if (r_found) begin
                                r_state <= S_RM_RD;
                            end else begin
                                r_out.status <= rse_pkg::STATUS_MISS;
                                r_valid      <= 1'b1;
                            end
                        end
                        rse_pkg::FUNC_CONTAINS: begin
                            r_out.status <= r_found ? rse_pkg::STATUS_SUCCESS
                                                    : rse_pkg::STATUS_MISS;
                            r_valid      <= 1'b1;
                        end
                        default: begin
                            r_out.status <= rse_pkg::STATUS_EMPTY;
                            r_valid      <= 1'b1;
                        end
                    endcase
                end

                S_RM_RD: begin
                    r_state <= S_RM_WR;
                end

                S_RM_WR: begin
                    // last element is written into the freed slot this cycle
                    r_count             <= last_slot;
                    r_out.status        <= rse_pkg::STATUS_SUCCESS;
                    r_out.result_value  <= '0;
                    r_out.element_count <= last_slot;
                    r_valid             <= 1'b1;
                    r_state             <= S_IDLE;
                end

                S_DIV: begin
                    r_rem  <= next_rem;
                    r_word <= {r_word[rse_pkg::WORD_BITS-2:0], 1'b0};
                    r_step <= r_step + 1'b1;
                    if (r_step == rse_pkg::STEP_BITS'(rse_pkg::WORD_BITS - 1)) begin
                        r_state <= S_GR_RD;
                    end
                end

                S_GR_RD: begin
                    r_state <= S_GR_OUT;
                end

                S_GR_OUT: begin
                    r_out.status        <= rse_pkg::STATUS_SUCCESS;
                    r_out.result_value  <= 32'(r_rdata);
                    r_out.element_count <= r_count;
                    r_valid             <= 1'b1;
                    r_state             <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted command either makes the block busy or is answered at once
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted command neither busy nor answered");

    // the result strobe only shows up once the sequencer is back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    // the count never runs past the store size
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rse_pkg::COUNT_BITS'(rse_pkg::CAPACITY))
        else $error("element count beyond capacity");

    // full is only reported when the store really is full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == rse_pkg::STATUS_FULL)
        |-> (o_result.element_count == rse_pkg::COUNT_BITS'(rse_pkg::CAPACITY)))
        else $error("store full reported below capacity");

    // a nonzero value is only returned by a successful pick
    a_value_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.result_value != '0)
        |-> (o_result.status == rse_pkg::STATUS_SUCCESS))
        else $error("result value on a failed operation");

endmodule
